// ----- rtl/assert_macros.svh -----
// Assertion helpers for the rate control checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- rtl/dcqcn_rc_pkg.sv -----
package dcqcn_rc_pkg;

    localparam int AFB = 16;              // alpha fraction bits
    localparam int AW  = AFB + 1;         // alpha width, holds one
    localparam int RW  = 20;              // rate width
    localparam int TW  = 48;              // timestamp width
    localparam int PW  = 32;              // period / elapsed width
    localparam int GW  = 17;              // gain register width
    localparam int FLW = 6;               // flow field width

    localparam logic [AW-1:0] ONE_Q = AW'(1) << AFB;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_INIT_RATE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_RATE  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GAIN      = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INC_PER   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ALP_PER   = 3'd5;

    localparam logic [RW-1:0] RST_INIT_RATE = 20'd100000;
    localparam logic [RW-1:0] RST_MIN_RATE  = 20'd10;
    localparam logic [GW-1:0] RST_GAIN      = 17'd256;
    localparam logic [PW-1:0] RST_PERIOD    = 32'd55;

    localparam logic [1:0] KIND_CNP = 2'd0;
    localparam logic [1:0] KIND_ADV = 2'd1;
    localparam logic [1:0] KIND_QRY = 2'd2;

    typedef enum logic [1:0] {OP_CNP, OP_ADV, OP_QRY} t_op;

    typedef struct packed {
        logic [1:0]     kind;
        logic [FLW-1:0] flow;
        logic [TW-1:0]  cnp_time;
        logic [PW-1:0]  elapsed;
    } t_req;

    typedef struct packed {
        logic [RW-1:0] rate_mbps;
        logic          flow_known;
    } t_rsp;

    typedef struct packed {
        t_op            op;
        logic           ok;
        logic [FLW-1:0] flow;
        logic [TW-1:0]  arg;    // CNP time or elapsed
    } t_cmd;

    typedef struct packed {
        logic          active;
        logic          rec;
        logic [RW-1:0] cur;
        logic [RW-1:0] tgt;
        logic [AW-1:0] alpha;
        logic [TW-1:0] last;
        logic [TW-1:0] inc_st;
        logic [TW-1:0] alp_st;
    } t_ent;

    typedef struct packed {
        logic          enable;
        logic [RW-1:0] init_rate;
        logic [RW-1:0] min_rate;
        logic [GW-1:0] gain;
        logic [PW-1:0] inc_per;
        logic [PW-1:0] alp_per;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_bstat;

endpackage

// ----- rtl/dcqcn_rc_stream_if.sv -----
interface dcqcn_rc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dcqcn_rate_control_core.sv -----
// DCQCN reaction point for up to NUM_FLOWS flows. Request beats carry kind
// (0 CNP, 1 time advance, 2 rate query), flow, cnp_time and elapsed; a query
// returns one response beat with the flow's rate and whether the flow is
// known, every other kind returns nothing. A CNP creates the flow at the
// initial rate with alpha one and cuts its rate by alpha/2 (floored at
// min_rate); a time advance moves the microsecond clock and, when enabled,
// walks the whole flow table doing timed recovery and the alpha update.
// In the executor a query passes through accept, table read and response
// load; a CNP through accept, read and multiply, and write-back; a time
// advance through accept and then one read and one write-back per table
// entry on the single-write, single-read flow memory, or accept alone while
// disabled. A query waits in the executor while the previous response beat
// is still held. A two-beat command queue sits in front, so requests keep
// landing while the executor works and while a response waits to be taken,
// until the queue is full. After reset the flow table is swept clear, during
// which requests are held off; config writes are taken at any time but
// belong in idle periods.
module dcqcn_rate_control_core #(
    parameter int NUM_FLOWS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dcqcn_rc_stream_if.sink                 i_req_ch,
    dcqcn_rc_stream_if.source               o_rsp_ch,
    input  logic                            i_cfg_we,
    input  logic [dcqcn_rc_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [dcqcn_rc_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import dcqcn_rc_pkg::*;

    t_cfg   r_cfg;
    t_cmd   cmd;
    logic   cmd_valid;
    logic   cmd_ready;
    t_bstat bstat;

    // Config register file, write only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b1;
            r_cfg.init_rate <= RST_INIT_RATE;
            r_cfg.min_rate  <= RST_MIN_RATE;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.inc_per   <= RST_PERIOD;
            r_cfg.alp_per   <= RST_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_cfg.enable    <= i_cfg_wdata[0];
                CFG_INIT_RATE: r_cfg.init_rate <= i_cfg_wdata[RW-1:0];
                CFG_MIN_RATE:  r_cfg.min_rate  <= i_cfg_wdata[RW-1:0];
                CFG_GAIN:      r_cfg.gain      <= i_cfg_wdata[GW-1:0];
                CFG_INC_PER:   r_cfg.inc_per   <= i_cfg_wdata[PW-1:0];
                CFG_ALP_PER:   r_cfg.alp_per   <= i_cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // Front: takes request beats, drops what has no effect, queues commands.
    dcqcn_rc_front #(.NUM_FLOWS(NUM_FLOWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_ch    (i_req_ch),
        .i_enable    (r_cfg.enable),
        .i_bstat     (bstat),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Back: flow table, table sweep, response register.
    dcqcn_rc_back #(.NUM_FLOWS(NUM_FLOWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_bstat     (bstat),
        .o_rsp_ch    (o_rsp_ch)
    );

endmodule

// ----- rtl/dcqcn_rc_front.sv -----
module dcqcn_rc_front #(
    parameter int NUM_FLOWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dcqcn_rc_stream_if.sink      i_req_ch,
    input  logic                 i_enable,
    input  dcqcn_rc_pkg::t_bstat i_bstat,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output dcqcn_rc_pkg::t_cmd   o_cmd
);
    import dcqcn_rc_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic [1:0] r_cnt;
    logic       r_rp;
    logic       r_wp;

    t_req req;
    t_cmd cmd;
    logic acc;
    logic keep;
    logic push;
    logic pop;

    always_comb begin
        req            = i_req_ch.data;
        i_req_ch.ready = (r_cnt != 2'(QD)) && !i_bstat.clearing;
        acc            = i_req_ch.valid && i_req_ch.ready;
        cmd.flow       = req.flow;
        cmd.ok         = int'(req.flow) < NUM_FLOWS;
        cmd.arg        = req.cnp_time;
        cmd.op         = OP_QRY;
        keep           = 1'b0;
        case (req.kind)
            KIND_CNP: begin
                cmd.op = OP_CNP;
                keep   = i_enable && cmd.ok;   // disabled or off-table CNP is dropped
            end
            KIND_ADV: begin
                cmd.op  = OP_ADV;
                cmd.arg = TW'(req.elapsed);
                keep    = 1'b1;
            end
            KIND_QRY: begin
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
        push        = acc && keep;
        o_cmd_valid = r_cnt != 2'd0;
        o_cmd       = r_q[r_rp];
        pop         = o_cmd_valid && i_cmd_ready;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/dcqcn_rc_back.sv -----
module dcqcn_rc_back #(
    parameter int NUM_FLOWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcqcn_rc_pkg::t_cfg   i_cfg,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  dcqcn_rc_pkg::t_cmd   i_cmd,
    output dcqcn_rc_pkg::t_bstat o_bstat,
    dcqcn_rc_stream_if.source    o_rsp_ch
);
    import dcqcn_rc_pkg::*;

    localparam int FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam logic [FW-1:0] LAST = FW'(NUM_FLOWS - 1);
    localparam int MW = RW + AW + 1;   // multiplier product width

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_EV, S_WR} t_state;

    t_ent mem [NUM_FLOWS];

    t_state          r_state, n_state;
    logic [FW-1:0]   r_addr, n_addr;
    t_cmd            r_cmd, n_cmd;
    logic [TW-1:0]   r_now, n_now;
    t_ent            r_q;
    t_ent            r_ent, n_ent;
    logic [MW-1:0]   r_prod, n_prod;
    logic            r_do_inc, n_do_inc;
    logic            r_do_alp, n_do_alp;
    logic            r_hit, n_hit;
    logic [RW-1:0]   r_tgt, n_tgt;
    logic            r_ov, n_ov;
    t_rsp            r_rsp, n_rsp;
    logic [RW:0]     r_inc;
    logic [AW-1:0]   r_gsat;

    logic            we;
    logic [FW-1:0]   wa;
    t_ent            wd;
    logic [FW+5:0]   flow_x;
    t_ent            eff;
    logic [RW-1:0]   mul_a;
    logic [AW:0]     mul_b;
    logic [TW-1:0]   d_inc, d_alp, d_cnp;
    logic [RW+1:0]   t_sum;
    logic [RW:0]     c_new;
    logic [RW:0]     r_dec;
    logic [AW:0]     a_new;
    logic            out_free;

    // Config-derived constants, refreshed every cycle.
    always_ff @(posedge i_clk) begin
        r_inc  <= (RW+1)'((37'(i_cfg.init_rate) * 37'(i_cfg.gain)) >> AFB);
        r_gsat <= (i_cfg.gain > GW'(ONE_Q)) ? ONE_Q : AW'(i_cfg.gain);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_q <= mem[n_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cmd       = r_cmd;
        n_now       = r_now;
        n_ent       = r_ent;
        n_prod      = r_prod;
        n_do_inc    = r_do_inc;
        n_do_alp    = r_do_alp;
        n_hit       = r_hit;
        n_tgt       = r_tgt;
        n_rsp       = r_rsp;
        out_free    = !r_ov || o_rsp_ch.ready;
        n_ov        = r_ov && !o_rsp_ch.ready;
        o_cmd_ready = 1'b0;
        we          = 1'b0;
        wa          = r_addr;
        wd          = r_ent;
        flow_x      = (FW+6)'(i_cmd.flow);
        eff         = r_q;
        mul_a       = r_q.cur;
        mul_b       = (AW+1)'(r_q.alpha);
        d_inc       = r_now - r_q.inc_st;
        d_alp       = r_now - r_q.alp_st;
        d_cnp       = r_now - r_q.last;
        t_sum       = (RW+2)'(r_q.tgt) + (RW+2)'(r_inc);
        c_new       = (RW+1)'(((RW+2)'(r_ent.cur) + (RW+2)'(r_tgt) + (RW+2)'(1)) >> 1);
        r_dec       = r_prod[MW-1:AFB+1];
        a_new       = (AW+1)'(r_prod >> AFB) + (r_hit ? (AW+1)'(r_gsat) : (AW+1)'(0));

        case (r_state)
            S_CLR: begin
                we = 1'b1;
                wd = '0;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + FW'(1);
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.op == OP_ADV) begin
                        n_now = r_now + i_cmd.arg;
                        if (i_cfg.enable) begin
                            n_addr  = '0;
                            n_state = S_EV;
                        end
                    end else begin
                        n_addr  = flow_x[FW-1:0];
                        n_state = S_EV;
                    end
                end
            end
            S_EV: begin
                case (r_cmd.op)
                    OP_QRY: begin
                        if (out_free) begin
                            n_ov = 1'b1;
                            if (r_cmd.ok && r_q.active) begin
                                n_rsp.rate_mbps  = r_q.cur;
                                n_rsp.flow_known = 1'b1;
                            end else begin
                                n_rsp.rate_mbps  = i_cfg.init_rate;
                                n_rsp.flow_known = 1'b0;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_CNP: begin
                        if (!r_q.active) begin
                            eff.cur    = i_cfg.init_rate;
                            eff.tgt    = i_cfg.init_rate;
                            eff.alpha  = ONE_Q;
                            eff.inc_st = r_now;
                            eff.alp_st = r_now;
                        end
                        mul_a   = eff.cur;
                        mul_b   = ((AW+1)'(ONE_Q) << 1) - (AW+1)'(eff.alpha);
                        n_prod  = MW'(mul_a) * MW'(mul_b);
                        n_ent   = eff;
                        n_state = S_WR;
                    end
                    default: begin
                        mul_a    = RW'(ONE_Q - r_gsat);
                        n_prod   = MW'(mul_a) * MW'(mul_b);
                        n_do_inc = r_q.rec && (d_inc >= TW'(i_cfg.inc_per));
                        n_do_alp = d_alp >= TW'(i_cfg.alp_per);
                        n_hit    = d_cnp < TW'(i_cfg.alp_per);
                        n_tgt    = (t_sum > (RW+2)'(i_cfg.init_rate)) ? i_cfg.init_rate
                                                                     : t_sum[RW-1:0];
                        n_ent    = r_q;
                        n_state  = S_WR;
                    end
                endcase
            end
            S_WR: begin
                if (r_cmd.op == OP_CNP) begin
                    if (r_dec < (RW+1)'(i_cfg.min_rate)) begin
                        wd.cur = i_cfg.min_rate;
                    end else begin
                        wd.cur = r_dec[RW-1:0];
                    end
                    wd.tgt    = wd.cur;
                    wd.last   = r_cmd.arg;
                    wd.rec    = 1'b1;
                    wd.active = 1'b1;
                    we        = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    if (r_do_inc) begin
                        if (c_new >= (RW+1)'(i_cfg.init_rate)) begin
                            wd.rec = 1'b0;
                            wd.cur = i_cfg.init_rate;
                        end else begin
                            wd.cur = c_new[RW-1:0];
                        end
                        wd.tgt    = r_tgt;
                        wd.inc_st = r_now;
                    end
                    if (r_do_alp) begin
                        wd.alpha  = (a_new > (AW+1)'(ONE_Q)) ? ONE_Q : a_new[AW-1:0];
                        wd.alp_st = r_now;
                    end
                    we = r_ent.active;
                    if (r_addr == LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + FW'(1);
                        n_state = S_EV;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_now   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_now   <= n_now;
            r_ov    <= n_ov;
        end
        r_cmd    <= n_cmd;
        r_ent    <= n_ent;
        r_prod   <= n_prod;
        r_do_inc <= n_do_inc;
        r_do_alp <= n_do_alp;
        r_hit    <= n_hit;
        r_tgt    <= n_tgt;
        r_rsp    <= n_rsp;
    end

    assign o_bstat.clearing = r_state == S_CLR;
    assign o_rsp_ch.valid   = r_ov;
    assign o_rsp_ch.data    = r_rsp;

endmodule

// ----- rtl/dcqcn_rc_checker.sv -----
`include "assert_macros.svh"

module dcqcn_rc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [dcqcn_rc_pkg::RW-1:0]     i_rsp_rate,
    input logic                            i_rsp_known,
    input logic                            i_cfg_we,
    input logic [dcqcn_rc_pkg::CFG_IW-1:0] i_cfg_idx,
    input logic [dcqcn_rc_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import dcqcn_rc_pkg::*;

    logic [RW-1:0] r_init;

    // Shadow of the initial rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= RST_INIT_RATE;
        end else if (i_cfg_we && (i_cfg_idx == CFG_INIT_RATE)) begin
            r_init <= i_cfg_wdata[RW-1:0];
        end
    end

    `ASSERT_RUN(a_clear_holds_req, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_req_ready)
    `ASSERT_RUN(a_no_rsp_after_rst, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_rsp_valid)
    `ASSERT_RUN(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_rate) && $stable(i_rsp_known))
    `ASSERT_ALL(a_unknown_rate, i_clk, i_rst_n && i_rsp_valid && !i_rsp_known |-> i_rsp_rate == r_init)

endmodule

bind dcqcn_rate_control_core dcqcn_rc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req_ch.ready),
    .i_rsp_valid (o_rsp_ch.valid),
    .i_rsp_ready (o_rsp_ch.ready),
    .i_rsp_rate  (o_rsp_ch.data.rate_mbps),
    .i_rsp_known (o_rsp_ch.data.flow_known),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_wdata (i_cfg_wdata)
);
